// ===== hw/rtl/missing_packet_retry_scheduler_top_assert.svh =====
// Assertion macros shared by the retry scheduler RTL.
// Needs a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef MISSING_PACKET_RETRY_SCHEDULER_TOP_ASSERT_SVH
`define MISSING_PACKET_RETRY_SCHEDULER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MPRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MPRS_ASSERT_NEVER(lbl, expr, msg) \
	`MPRS_ASSERT(lbl, !(expr), msg)
`else
`define MPRS_ASSERT(lbl, prop, msg)
`define MPRS_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== hw/rtl/mprs_pkg.sv =====
// Types and codes for the missing packet retry scheduler.
// No dependencies; used by mprs_ctrl, mprs_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none
package mprs_pkg;

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] range_start;
		logic [63:0] range_end;
		logic [15:0] id_step;
		logic [63:0] packet_id;
		logic [63:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] retry_id;
		logic        batch_end;
		logic        last;
	} result_t;

	localparam logic [1:0] OP_ADD     = 2'd0;
	localparam logic [1:0] OP_NOTIFY  = 2'd1;
	localparam logic [1:0] OP_TICK    = 2'd2;
	localparam logic [1:0] OP_RESTART = 2'd3;

	localparam logic [1:0] KIND_RETRY    = 2'd0;
	localparam logic [1:0] KIND_ACCEPTED = 2'd1;
	localparam logic [1:0] KIND_REFUSED  = 2'd2;
	localparam logic [1:0] KIND_EMPTY    = 2'd3;

	localparam logic [3:0] A_NONE      = 4'd0;
	localparam logic [3:0] A_ADD_CHK   = 4'd1;
	localparam logic [3:0] A_ADD_FILL  = 4'd2;
	localparam logic [3:0] A_NOT_SCAN  = 4'd3;
	localparam logic [3:0] A_NOT_REM   = 4'd4;
	localparam logic [3:0] A_NOT_FREE  = 4'd5;
	localparam logic [3:0] A_TICK_DUE  = 4'd6;
	localparam logic [3:0] A_TICK_PICK = 4'd7;
	localparam logic [3:0] A_TICK_IDS  = 4'd8;
	localparam logic [3:0] A_TICK_END  = 4'd9;
	localparam logic [3:0] A_CLEAR     = 4'd10;

	typedef struct packed {
		logic [3:0] act;
		logic       first;
		logic       load;
	} cmd_t;

	typedef struct packed {
		logic add_go;
		logic fill_done;
		logic scan_done;
		logic bscan_done;
		logic hit;
		logic pick_found;
	} status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mprs_dp.sv =====
// Datapath: batch table, id store memory, scan counters and result register.
// Depends on mprs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "missing_packet_retry_scheduler_top_assert.svh"
module mprs_dp import mprs_pkg::*; #(
	parameter int MAX_IDS = 64,
	parameter int MAX_BATCHES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire item_t       item,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire cmd_t        cmd,
	output status_t          stat,
	output logic             strobe,
	output result_t          result
);
	localparam int IW = $clog2(MAX_IDS);
	localparam int BW = (MAX_BATCHES > 1) ? $clog2(MAX_BATCHES) : 1;
	localparam logic [IW:0] NI = (IW+1)'(MAX_IDS);
	localparam logic [BW:0] NB = (BW+1)'(MAX_BATCHES);

	item_t            it_q;
	logic [31:0]      ivl_q;
	logic [63:0]      seq_q;
	logic [63:0]      dl_q [MAX_BATCHES];
	logic [MAX_BATCHES-1:0] bv_q, due_q;
	logic [MAX_IDS-1:0] iv_q;
	logic [IW:0]      used_q, cnt_q;
	logic [BW:0]      bcnt_q;
	logic             vld_s1;
	logic [IW-1:0]    idx_s1;
	logic [64+BW-1:0] id_mem [MAX_IDS];
	logic [64+BW-1:0] rd_s1;
	logic [IW+16:0]   prod_q;
	logic [64:0]      cur_q;
	logic [BW-1:0]    fill_b_q, best_b_q, pick_q;
	logic [IW-1:0]    best_idx_q;
	logic [63:0]      best_dl_q, pick_dl_q, next_q, pend_id_q;
	logic             hit_q, left_q, pick_v_q, pend_v_q, pend_be_q;
	logic             strobe_q;
	result_t          res_q;

	logic [15:0]   step_eff;
	logic [IW:0]   free_cnt;
	logic [64:0]   need;
	logic          empty, no_room, fb_v, fill_done, scan_done, bscan_done, n_earl;
	logic [BW-1:0] fb, bidx, rd_own;
	logic [IW-1:0] sidx;
	logic [63:0]   rd_val, dl_rd;
	logic [64:0]   sum;
	logic          id_scan, b_scan, emit;

	assign step_eff = (it_q.id_step == 16'd0) ? 16'd1 : it_q.id_step;
	assign free_cnt = NI - used_q;
	assign need = {1'b0, it_q.range_start} + 65'(prod_q);
	assign no_room = need < {1'b0, it_q.range_end};
	assign empty = it_q.range_start >= it_q.range_end;
	assign sidx = cnt_q[IW-1:0];
	assign bidx = bcnt_q[BW-1:0];
	assign rd_val = rd_s1[63:0];
	assign rd_own = rd_s1[64+BW-1:64];
	assign dl_rd = (cmd.act == A_NOT_SCAN) ? dl_q[rd_own] : dl_q[bidx];
	assign sum = {1'b0, it_q.now_ms} + {33'd0, ivl_q};
	assign fill_done = cur_q >= {1'b0, it_q.range_end};
	assign scan_done = !cmd.first && (cnt_q == NI) && !vld_s1;
	assign bscan_done = !cmd.first && (bcnt_q == NB);
	assign n_earl = !hit_q || (dl_rd < best_dl_q) || (dl_rd == best_dl_q && rd_own < best_b_q);
	assign id_scan = (cmd.act == A_NOT_SCAN) || (cmd.act == A_NOT_REM) || (cmd.act == A_TICK_IDS);
	assign b_scan = (cmd.act == A_TICK_DUE) || (cmd.act == A_TICK_PICK);

	// raise the result strobe for one cycle
	assign emit = ((cmd.act == A_ADD_CHK) && (empty || no_room || !fb_v)) ||
		((cmd.act == A_ADD_FILL) && fill_done) ||
		((cmd.act == A_TICK_IDS) && !cmd.first && !scan_done && vld_s1 && iv_q[idx_s1] &&
			(rd_own == pick_q) && pend_v_q) ||
		((cmd.act == A_TICK_END) && pend_v_q);

	// lowest free batch slot
	always_comb begin
		fb = '0;
		fb_v = 1'b0;
		for (int b = MAX_BATCHES - 1; b >= 0; b--) begin
			if (!bv_q[b]) begin
				fb = BW'(b);
				fb_v = 1'b1;
			end
		end
	end

	assign stat.add_go = !empty && !no_room && fb_v;
	assign stat.fill_done = fill_done;
	assign stat.scan_done = scan_done;
	assign stat.bscan_done = bscan_done;
	assign stat.hit = hit_q;
	assign stat.pick_found = pick_v_q;

	assign strobe = strobe_q;
	assign result = res_q;

	always_ff @(posedge clk) begin
		if (cmd.act == A_ADD_FILL && !fill_done && !iv_q[sidx]) begin
			id_mem[sidx] <= {fill_b_q, cur_q[63:0]};
		end
		if (cnt_q < NI) begin
			rd_s1 <= id_mem[sidx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q <= '0;
			ivl_q <= 32'd100;
			seq_q <= '0;
			for (int b = 0; b < MAX_BATCHES; b++) dl_q[b] <= '0;
			bv_q <= '0;
			due_q <= '0;
			iv_q <= '0;
			used_q <= '0;
			cnt_q <= '0;
			bcnt_q <= '0;
			vld_s1 <= 1'b0;
			idx_s1 <= '0;
			prod_q <= '0;
			cur_q <= '0;
			fill_b_q <= '0;
			best_b_q <= '0;
			best_idx_q <= '0;
			best_dl_q <= '0;
			pick_q <= '0;
			pick_dl_q <= '0;
			next_q <= '0;
			pend_id_q <= '0;
			hit_q <= 1'b0;
			left_q <= 1'b0;
			pick_v_q <= 1'b0;
			pend_v_q <= 1'b0;
			pend_be_q <= 1'b0;
			strobe_q <= 1'b0;
			res_q <= '0;
		end else begin
			strobe_q <= emit;
			prod_q <= (IW+17)'(free_cnt) * (IW+17)'(step_eff);
			if (cfg_we) ivl_q <= cfg_wdata;
			if (cmd.load) it_q <= item;

			// advance the id scan: address now, data in the next cycle
			if (id_scan) begin
				if (cmd.first) begin
					cnt_q <= '0;
					vld_s1 <= 1'b0;
				end else if (cnt_q < NI) begin
					vld_s1 <= 1'b1;
					idx_s1 <= sidx;
					cnt_q <= cnt_q + 1'b1;
				end else begin
					vld_s1 <= 1'b0;
				end
			end
			if (b_scan) begin
				if (cmd.first) bcnt_q <= '0;
				else if (bcnt_q < NB) bcnt_q <= bcnt_q + 1'b1;
			end

			unique case (cmd.act)
				A_ADD_CHK: begin
					cnt_q <= '0;
					cur_q <= {1'b0, it_q.range_start};
					fill_b_q <= fb;
					if (empty) begin
						res_q <= {KIND_EMPTY, 64'd0, 1'b0, 1'b1};
					end else if (!(no_room == 1'b0 && fb_v)) begin
						res_q <= {KIND_REFUSED, 64'd0, 1'b0, 1'b1};
					end else begin
						seq_q <= seq_q + 64'd1;
						bv_q[fb] <= 1'b1;
						dl_q[fb] <= seq_q + 64'd1;
					end
				end
				A_ADD_FILL: begin
					if (fill_done) begin
						res_q <= {KIND_ACCEPTED, 64'd0, 1'b0, 1'b1};
					end else begin
						if (!iv_q[sidx]) begin
							iv_q[sidx] <= 1'b1;
							used_q <= used_q + 1'b1;
							cur_q <= cur_q + {49'd0, step_eff};
						end
						cnt_q <= cnt_q + 1'b1;
					end
				end
				A_NOT_SCAN: begin
					if (cmd.first) begin
						hit_q <= 1'b0;
					end else if (vld_s1 && iv_q[idx_s1] && rd_val == it_q.packet_id && n_earl) begin
						hit_q <= 1'b1;
						best_idx_q <= idx_s1;
						best_b_q <= rd_own;
						best_dl_q <= dl_rd;
					end
				end
				A_NOT_REM: begin
					if (cmd.first) begin
						iv_q[best_idx_q] <= 1'b0;
						used_q <= used_q - 1'b1;
						left_q <= 1'b0;
					end else if (vld_s1 && iv_q[idx_s1] && rd_own == best_b_q) begin
						left_q <= 1'b1;
					end
				end
				A_NOT_FREE: begin
					if (!left_q) bv_q[best_b_q] <= 1'b0;
				end
				A_TICK_DUE: begin
					if (cmd.first) begin
						pend_v_q <= 1'b0;
						next_q <= sum[64] ? '1 : sum[63:0];
					end else if (bcnt_q < NB) begin
						due_q[bidx] <= bv_q[bidx] && (dl_rd <= it_q.now_ms);
					end
				end
				A_TICK_PICK: begin
					if (cmd.first) begin
						pick_v_q <= 1'b0;
					end else if (bcnt_q < NB && due_q[bidx] && (!pick_v_q || dl_rd < pick_dl_q)) begin
						pick_v_q <= 1'b1;
						pick_q <= bidx;
						pick_dl_q <= dl_rd;
					end
				end
				A_TICK_IDS: begin
					if (cmd.first) begin
						due_q[pick_q] <= 1'b0;
						dl_q[pick_q] <= next_q;
					end else if (scan_done) begin
						pend_be_q <= 1'b1;
					end else if (vld_s1 && iv_q[idx_s1] && rd_own == pick_q) begin
						// hold each id one step so the batch and item ends can be marked
						if (pend_v_q) begin
							res_q <= {KIND_RETRY, pend_id_q, pend_be_q, 1'b0};
						end
						pend_v_q <= 1'b1;
						pend_id_q <= rd_val;
						pend_be_q <= 1'b0;
					end
				end
				A_TICK_END: begin
					if (pend_v_q) begin
						res_q <= {KIND_RETRY, pend_id_q, pend_be_q, 1'b1};
						pend_v_q <= 1'b0;
					end
				end
				A_CLEAR: begin
					bv_q <= '0;
					iv_q <= '0;
					used_q <= '0;
					for (int b = 0; b < MAX_BATCHES; b++) dl_q[b] <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	`MPRS_ASSERT(a_used_bound, used_q <= NI, "id store count exceeds capacity")
	`MPRS_ASSERT(a_status_last, (strobe_q && res_q.kind != KIND_RETRY) |-> (res_q.last && res_q.retry_id == 64'd0), "status result malformed")
	`MPRS_ASSERT_NEVER(a_fill_overrun, cmd.act == A_ADD_FILL && !fill_done && cnt_q == NI, "fill ran past the id store")
endmodule
`default_nettype wire

// ===== hw/rtl/mprs_ctrl.sv =====
// Controller: sequences add, notify, tick and restart through the datapath.
// Depends on mprs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "missing_packet_retry_scheduler_top_assert.svh"
module mprs_ctrl import mprs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] op,
	input  wire status_t    stat,
	output logic            busy,
	output cmd_t            cmd
);
	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_ADD_MUL   = 4'd1;
	localparam logic [3:0] S_ADD_CHK   = 4'd2;
	localparam logic [3:0] S_ADD_FILL  = 4'd3;
	localparam logic [3:0] S_NOT_SCAN  = 4'd4;
	localparam logic [3:0] S_NOT_REM   = 4'd5;
	localparam logic [3:0] S_NOT_FREE  = 4'd6;
	localparam logic [3:0] S_TICK_DUE  = 4'd7;
	localparam logic [3:0] S_TICK_PICK = 4'd8;
	localparam logic [3:0] S_TICK_IDS  = 4'd9;
	localparam logic [3:0] S_TICK_END  = 4'd10;
	localparam logic [3:0] S_CLEAR     = 4'd11;

	logic [3:0] state_q, state_nxt;
	logic       first_q;
	logic [3:0] act;

	always_comb begin
		state_nxt = state_q;
		act = A_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (op)
						OP_ADD:     state_nxt = S_ADD_MUL;
						OP_NOTIFY:  state_nxt = S_NOT_SCAN;
						OP_TICK:    state_nxt = S_TICK_DUE;
						OP_RESTART: state_nxt = S_CLEAR;
						default:    state_nxt = S_IDLE;
					endcase
				end
			end
			S_ADD_MUL: state_nxt = S_ADD_CHK;
			S_ADD_CHK: begin
				act = A_ADD_CHK;
				state_nxt = stat.add_go ? S_ADD_FILL : S_IDLE;
			end
			S_ADD_FILL: begin
				act = A_ADD_FILL;
				if (stat.fill_done) state_nxt = S_IDLE;
			end
			S_NOT_SCAN: begin
				act = A_NOT_SCAN;
				if (stat.scan_done) state_nxt = stat.hit ? S_NOT_REM : S_IDLE;
			end
			S_NOT_REM: begin
				act = A_NOT_REM;
				if (stat.scan_done) state_nxt = S_NOT_FREE;
			end
			S_NOT_FREE: begin
				act = A_NOT_FREE;
				state_nxt = S_IDLE;
			end
			S_TICK_DUE: begin
				act = A_TICK_DUE;
				if (stat.bscan_done) state_nxt = S_TICK_PICK;
			end
			S_TICK_PICK: begin
				act = A_TICK_PICK;
				if (stat.bscan_done) state_nxt = stat.pick_found ? S_TICK_IDS : S_TICK_END;
			end
			S_TICK_IDS: begin
				act = A_TICK_IDS;
				if (stat.scan_done) state_nxt = S_TICK_PICK;
			end
			S_TICK_END: begin
				act = A_TICK_END;
				state_nxt = S_IDLE;
			end
			S_CLEAR: begin
				act = A_CLEAR;
				state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// mark the first cycle of every new phase
			first_q <= state_nxt != state_q;
		end
	end

	assign busy = state_q != S_IDLE;
	assign cmd.act = act;
	assign cmd.first = first_q;
	assign cmd.load = start && (state_q == S_IDLE);

	`MPRS_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted transaction did not raise busy")
	`MPRS_ASSERT(a_clear_short, (state_q == S_CLEAR) |=> (state_q == S_IDLE), "restart took more than one cycle")
	`MPRS_ASSERT(a_pick_first, (state_q == S_TICK_IDS && $past(state_q) == S_TICK_PICK) |-> first_q, "phase start not marked")
endmodule
`default_nettype wire

// ===== hw/rtl/missing_packet_retry_scheduler_top.sv =====
// Missing packet retry scheduler. Per transaction, with N = MAX_IDS and B = MAX_BATCHES:
// restart clears the tables; add reports empty or refused, else fills ids walking id slots (at most N);
// notify makes one pass over the id memory, and a second one on a hit (one read port);
// tick marks due batches among B, then scans the ids of each; results stream during it.
// Status results and the final retry id strobe in the first cycle with busy low; no stalls.
// Asynchronous reset clears all control state and the batch table; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module missing_packet_retry_scheduler_top import mprs_pkg::*; #(
	parameter int MAX_IDS = 64,
	parameter int MAX_BATCHES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire item_t       item,
	output logic             strobe,
	output result_t          result,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata
);
	cmd_t    cmd;
	status_t stat;

	mprs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (item.op),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	mprs_dp #(
		.MAX_IDS     (MAX_IDS),
		.MAX_BATCHES (MAX_BATCHES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.strobe    (strobe),
		.result    (result)
	);
endmodule
`default_nettype wire
